>>> rtl/iaie_pkg.sv
// Shared types and constants for the indexed array block.
// Used by iaie_ctrl, iaie_dp and the top level; no dependencies.
package iaie_pkg;

  localparam int DEPTH  = 64;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CNT_W  = 7;
  localparam int POS_W  = 7;
  localparam int DATA_W = 32;

  typedef enum logic [2:0] {
    CMD_PUSH   = 3'd0,
    CMD_POP    = 3'd1,
    CMD_INSERT = 3'd2,
    CMD_ERASE  = 3'd3,
    CMD_READ   = 3'd4,
    CMD_WRITE  = 3'd5,
    CMD_FRONT  = 3'd6,
    CMD_BACK   = 3'd7
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_OOB   = 2'd1,
    ST_EMPTY = 2'd2,
    ST_FULL  = 2'd3
  } stat_t;

  typedef struct packed {
    cmd_t                      command;
    logic [POS_W-1:0]          position;
    logic signed [DATA_W-1:0]  item_value;
  } in_word_t;

  typedef struct packed {
    stat_t                     status;
    logic signed [DATA_W-1:0]  read_value;
    logic [CNT_W-1:0]          element_count;
    logic                      is_empty;
    logic [CNT_W-1:0]          reported_capacity;
  } out_word_t;

  // Datapath operation for the current cycle, issued by the controller.
  typedef enum logic [2:0] {
    OP_NONE,
    OP_LOAD,
    OP_EXEC,
    OP_SHIFT,
    OP_PLACE,
    OP_CAPTURE,
    OP_EMIT
  } dp_op_t;

  // Datapath status seen by the controller.
  typedef struct packed {
    cmd_t command;
    logic is_err;
    logic at_pos;
    logic shift_last;
    logic out_free;
  } dp_stat_t;

endpackage

>>> rtl/iaie_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module iaie_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/iaie_ctrl.sv
// Controller state machine for the indexed array block.
// Depends on iaie_pkg; drives iaie_dp through dp_op_t.
module iaie_ctrl import iaie_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  dp_stat_t stat,
  output dp_op_t   op
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_SHIFT,
    S_PLACE,
    S_RDWAIT,
    S_FINISH
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    op        = OP_NONE;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op        = OP_LOAD;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        op        = OP_EXEC;
        state_nxt = S_FINISH;
        if (!stat.is_err) begin
          case (stat.command)
            CMD_READ, CMD_FRONT, CMD_BACK: state_nxt = S_RDWAIT;
            CMD_INSERT, CMD_ERASE: begin
              if (!stat.at_pos) state_nxt = S_SHIFT;
            end
            default: state_nxt = S_FINISH;
          endcase
        end
      end
      S_SHIFT: begin
        op = OP_SHIFT;
        if (stat.shift_last) begin
          state_nxt = (stat.command == CMD_INSERT) ? S_PLACE : S_FINISH;
        end
      end
      S_PLACE: begin
        op        = OP_PLACE;
        state_nxt = S_FINISH;
      end
      S_RDWAIT: begin
        op        = OP_CAPTURE;
        state_nxt = S_FINISH;
      end
      S_FINISH: begin
        if (stat.out_free) begin
          op        = OP_EMIT;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign in_stall = (state_r != S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

>>> rtl/iaie_dp.sv
// Datapath for the indexed array block: element RAM, count, capacity,
// walk pointer and output register. Depends on iaie_pkg and iaie_ram.
module iaie_dp import iaie_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  dp_op_t    op,
  output dp_stat_t  stat,
  input  in_word_t  in_word,
  output logic      out_valid,
  input  logic      out_stall,
  output out_word_t out_word
);

  cmd_t                     cmd_r, cmd_nxt;
  logic [POS_W-1:0]         pos_r, pos_nxt;
  logic signed [DATA_W-1:0] val_r, val_nxt;
  logic [CNT_W-1:0]         total_r, total_nxt;
  logic [CNT_W-1:0]         cap_r, cap_nxt;
  logic [ADDR_W-1:0]        ptr_r, ptr_nxt;
  stat_t                    stat_r, stat_nxt;
  logic signed [DATA_W-1:0] rdv_r, rdv_nxt;
  logic                     out_valid_r, out_valid_nxt;
  out_word_t                out_word_r, out_word_nxt;

  logic                     ram_we;
  logic [ADDR_W-1:0]        ram_waddr, ram_raddr;
  logic [DATA_W-1:0]        ram_wdata, ram_rdata;

  stat_t                    err;
  logic [CNT_W-1:0]         total_dec;
  logic [CNT_W:0]           cap_dbl;
  logic [CNT_W-1:0]         cap_grown;

  iaie_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign total_dec = total_r - CNT_W'(1);

  // Capacity doubles when the array is exactly filled to it, capped at DEPTH.
  always_comb begin
    cap_dbl   = (cap_r == '0) ? (CNT_W+1)'(1) : {cap_r, 1'b0};
    cap_grown = cap_r;
    if (total_r == cap_r) begin
      cap_grown = (cap_dbl > (CNT_W+1)'(DEPTH)) ? CNT_W'(DEPTH) : cap_dbl[CNT_W-1:0];
    end
  end

  always_comb begin
    err = ST_OK;
    case (cmd_r)
      CMD_PUSH: if (total_r >= CNT_W'(DEPTH)) err = ST_FULL;
      CMD_POP, CMD_FRONT, CMD_BACK: if (total_r == '0) err = ST_EMPTY;
      CMD_INSERT: begin
        if (pos_r > total_r) err = ST_OOB;
        else if (total_r >= CNT_W'(DEPTH)) err = ST_FULL;
      end
      default: if (pos_r >= total_r) err = ST_OOB;
    endcase
  end

  assign stat.command    = cmd_r;
  assign stat.is_err     = (err != ST_OK);
  assign stat.at_pos     = (cmd_r == CMD_INSERT) ? (pos_r == total_r) : (pos_r == total_dec);
  assign stat.shift_last = (cmd_r == CMD_INSERT) ? (ptr_r == pos_r[ADDR_W-1:0])
                                                 : (CNT_W'(ptr_r) == total_dec);
  assign stat.out_free   = !out_valid_r || !out_stall;

  always_comb begin
    cmd_nxt       = cmd_r;
    pos_nxt       = pos_r;
    val_nxt       = val_r;
    total_nxt     = total_r;
    cap_nxt       = cap_r;
    ptr_nxt       = ptr_r;
    stat_nxt      = stat_r;
    rdv_nxt       = rdv_r;
    out_word_nxt  = out_word_r;
    out_valid_nxt = out_valid_r && out_stall;
    ram_we        = 1'b0;
    ram_waddr     = pos_r[ADDR_W-1:0];
    ram_wdata     = val_r;
    ram_raddr     = ptr_r;

    case (op)
      OP_LOAD: begin
        cmd_nxt = in_word.command;
        pos_nxt = in_word.position;
        val_nxt = in_word.item_value;
        rdv_nxt = '0;
      end
      OP_EXEC: begin
        stat_nxt = err;
        if (err == ST_OK) begin
          case (cmd_r)
            CMD_PUSH: begin
              ram_we    = 1'b1;
              ram_waddr = total_r[ADDR_W-1:0];
              total_nxt = total_r + CNT_W'(1);
              cap_nxt   = cap_grown;
            end
            CMD_POP: total_nxt = total_dec;
            CMD_WRITE: ram_we = 1'b1;
            CMD_READ: ram_raddr = pos_r[ADDR_W-1:0];
            CMD_FRONT: ram_raddr = '0;
            CMD_BACK: ram_raddr = total_dec[ADDR_W-1:0];
            CMD_INSERT: begin
              cap_nxt = cap_grown;
              if (pos_r == total_r) begin
                ram_we    = 1'b1;
                total_nxt = total_r + CNT_W'(1);
              end else begin
                // walk down from the last element
                ram_raddr = total_dec[ADDR_W-1:0];
                ptr_nxt   = total_dec[ADDR_W-1:0];
              end
            end
            default: begin
              if (pos_r == total_dec) begin
                total_nxt = total_dec;
              end else begin
                ram_raddr = pos_r[ADDR_W-1:0] + ADDR_W'(1);
                ptr_nxt   = pos_r[ADDR_W-1:0] + ADDR_W'(1);
              end
            end
          endcase
        end
      end
      OP_SHIFT: begin
        // read of the next source overlaps the write of the previous one
        ram_we    = 1'b1;
        ram_wdata = ram_rdata;
        if (cmd_r == CMD_INSERT) begin
          ram_waddr = ptr_r + ADDR_W'(1);
          ram_raddr = ptr_r - ADDR_W'(1);
          ptr_nxt   = ptr_r - ADDR_W'(1);
        end else begin
          ram_waddr = ptr_r - ADDR_W'(1);
          ram_raddr = ptr_r + ADDR_W'(1);
          ptr_nxt   = ptr_r + ADDR_W'(1);
          if (stat.shift_last) total_nxt = total_dec;
        end
      end
      OP_PLACE: begin
        ram_we    = 1'b1;
        total_nxt = total_r + CNT_W'(1);
      end
      OP_CAPTURE: rdv_nxt = ram_rdata;
      OP_EMIT: begin
        out_valid_nxt                  = 1'b1;
        out_word_nxt.status            = stat_r;
        out_word_nxt.read_value        = rdv_r;
        out_word_nxt.element_count     = total_r;
        out_word_nxt.is_empty          = (total_r == '0);
        out_word_nxt.reported_capacity = cap_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r     <= '0;
      cap_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      total_r     <= total_nxt;
      cap_r       <= cap_nxt;
      out_valid_r <= out_valid_nxt;
    end
    cmd_r      <= cmd_nxt;
    pos_r      <= pos_nxt;
    val_r      <= val_nxt;
    ptr_r      <= ptr_nxt;
    stat_r     <= stat_nxt;
    rdv_r      <= rdv_nxt;
    out_word_r <= out_word_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

>>> rtl/indexed_array_insert_erase_top.sv
// Bounded ordered array of 64 signed 32-bit words with a dynamic-array command set.
// Input channel: in_valid / in_stall / in_word carry one command word
// (push, pop, insert, erase, read, write, front, back).
// Output channel: out_valid / out_stall / out_word carry one result word per
// command: status, read value, element count, empty flag, reported capacity.
// Commands are taken one at a time. Push, pop, write, insert at the end,
// erase of the last element and any rejected command go from execute to
// the result; read, front and back first capture the RAM read data. Insert
// at p below the count and erase below the last element walk a shift that
// moves one element per cycle through the single read and single write
// port of the element RAM; insert then places the new word.
// The next command is accepted once the current result is in the output
// register, even while the receiver stalls it; a second result waits until
// the first is taken. Reset clears the count and capacity; no clearing pass
// runs, and the block accepts a command in the first cycle after reset.
// Depends on iaie_pkg, iaie_ctrl, iaie_dp and iaie_ram.
module indexed_array_insert_erase_top import iaie_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_word_t  in_word,
  output logic      out_valid,
  input  logic      out_stall,
  output out_word_t out_word
);

  dp_op_t   op;
  dp_stat_t stat;

  iaie_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .op       (op)
  );

  iaie_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .op        (op),
    .stat      (stat),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

endmodule

>>> tb/sv/indexed_array_insert_erase_top_test.sv
// Self-checking testbench for indexed_array_insert_erase_top: directed, capacity,
// back-pressure and random command tests against a behavioral array predictor.
// Depends on iaie_pkg and the RTL of the block only.
module indexed_array_insert_erase_top_test;
  import iaie_pkg::*;

  localparam int QUIET_LIMIT = 5000;
  localparam int DRAIN_CYCLES = 100;
  localparam int RANDOM_PER_PHASE = 105;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_word_t  in_word = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_word_t out_word;

  // behavioral copy of the array
  logic signed [DATA_W-1:0] mirror_store [DEPTH];
  int unsigned mirror_count = 0;
  int unsigned mirror_cap = 0;

  out_word_t pending_results [$];
  int fail_count = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_request = 0;
  int hold_left = 0;
  int quiet_cycles = 0;
  int cmd_total [8];
  int status_total [4];
  int results_checked = 0;
  int peak_count = 0;

  indexed_array_insert_erase_top u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

  always #2 clk = ~clk;

  function automatic void grow_capacity();
    if (mirror_count == mirror_cap) begin
      if (mirror_cap == 0) mirror_cap = 1;
      else if (mirror_cap * 2 > DEPTH) mirror_cap = DEPTH;
      else mirror_cap = mirror_cap * 2;
    end
  endfunction

  function automatic out_word_t apply_command(in_word_t w);
    out_word_t r;
    int unsigned p;
    int i;
    r = '0;
    r.status = ST_OK;
    p = w.position;
    case (w.command)
      CMD_PUSH: begin
        if (mirror_count >= DEPTH) r.status = ST_FULL;
        else begin
          grow_capacity();
          mirror_store[mirror_count] = w.item_value;
          mirror_count++;
        end
      end
      CMD_POP: begin
        if (mirror_count == 0) r.status = ST_EMPTY;
        else mirror_count--;
      end
      CMD_INSERT: begin
        // range check wins over the full check
        if (p > mirror_count) r.status = ST_OOB;
        else if (mirror_count >= DEPTH) r.status = ST_FULL;
        else begin
          grow_capacity();
          for (i = mirror_count; i > p; i--) mirror_store[i] = mirror_store[i-1];
          mirror_store[p] = w.item_value;
          mirror_count++;
        end
      end
      CMD_ERASE: begin
        if (p >= mirror_count) r.status = ST_OOB;
        else begin
          for (i = p; i + 1 < mirror_count; i++) mirror_store[i] = mirror_store[i+1];
          mirror_count--;
        end
      end
      CMD_READ: begin
        if (p >= mirror_count) r.status = ST_OOB;
        else r.read_value = mirror_store[p];
      end
      CMD_WRITE: begin
        if (p >= mirror_count) r.status = ST_OOB;
        else mirror_store[p] = w.item_value;
      end
      CMD_FRONT: begin
        if (mirror_count == 0) r.status = ST_EMPTY;
        else r.read_value = mirror_store[0];
      end
      CMD_BACK: begin
        if (mirror_count == 0) r.status = ST_EMPTY;
        else r.read_value = mirror_store[mirror_count-1];
      end
      default: ;
    endcase
    r.element_count = CNT_W'(mirror_count);
    r.is_empty = (mirror_count == 0);
    r.reported_capacity = CNT_W'(mirror_cap);
    return r;
  endfunction

  function automatic in_word_t make_word(cmd_t c, int p, logic [DATA_W-1:0] v);
    in_word_t w;
    w.command = c;
    w.position = POS_W'(p);
    w.item_value = v;
    return w;
  endfunction

  // grow_pct sets how often a word adds an element; removal gets 60 - grow_pct
  function automatic in_word_t random_command(int grow_pct);
    in_word_t w;
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < grow_pct) w.command = ($urandom_range(1) != 0) ? CMD_PUSH : CMD_INSERT;
    else if (roll < 60) w.command = ($urandom_range(1) != 0) ? CMD_POP : CMD_ERASE;
    else begin
      case ($urandom_range(3))
        0: w.command = CMD_READ;
        1: w.command = CMD_WRITE;
        2: w.command = CMD_FRONT;
        default: w.command = CMD_BACK;
      endcase
    end
    if ($urandom_range(7) == 0) w.position = POS_W'($urandom_range(127));
    else if (w.command == CMD_INSERT) w.position = POS_W'($urandom_range(mirror_count));
    else if (mirror_count > 0) w.position = POS_W'($urandom_range(mirror_count - 1));
    else w.position = '0;
    if ($urandom_range(15) == 0) begin
      case ($urandom_range(3))
        0: w.item_value = 32'h7fff_ffff;
        1: w.item_value = 32'h8000_0000;
        2: w.item_value = '0;
        default: w.item_value = '1;
      endcase
    end else begin
      w.item_value = $urandom;
    end
    return w;
  endfunction

  // offer one word; prediction happens at the accepting edge
  task automatic send_word(in_word_t w);
    out_word_t predicted;
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_word <= w;
    do @(posedge clk); while (in_stall);
    predicted = apply_command(w);
    pending_results = {pending_results, predicted};
    cmd_total[int'(w.command)]++;
    if (mirror_count > peak_count) peak_count = mirror_count;
  endtask

  task automatic wait_drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic test_directed();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    send_word(make_word(CMD_FRONT, 0, '0));
    send_word(make_word(CMD_BACK, 0, '0));
    send_word(make_word(CMD_POP, 0, '0));
    send_word(make_word(CMD_READ, 0, '0));
    send_word(make_word(CMD_WRITE, 0, 32'h1234_5678));
    send_word(make_word(CMD_ERASE, 0, '0));
    send_word(make_word(CMD_INSERT, 1, 32'h5));
    send_word(make_word(CMD_INSERT, 0, 32'h5));
    send_word(make_word(CMD_PUSH, 127, 32'h7fff_ffff));
    send_word(make_word(CMD_PUSH, 0, 32'h8000_0000));
    send_word(make_word(CMD_INSERT, 1, 32'hffff_ffff));
    send_word(make_word(CMD_INSERT, mirror_count, 32'h0));
    send_word(make_word(CMD_READ, 64, '0));
    send_word(make_word(CMD_WRITE, 127, 32'hdead_beef));
    send_word(make_word(CMD_ERASE, 64, '0));
    send_word(make_word(CMD_READ, 1, '0));
    send_word(make_word(CMD_WRITE, 2, 32'h8000_0001));
    send_word(make_word(CMD_READ, 2, '0));
    send_word(make_word(CMD_FRONT, 0, '0));
    send_word(make_word(CMD_BACK, 0, '0));
    send_word(make_word(CMD_ERASE, 0, '0));
    send_word(make_word(CMD_ERASE, mirror_count - 1, '0));
    send_word(make_word(CMD_POP, 0, '0));
    send_word(make_word(CMD_BACK, 0, '0));
    wait_drain();
  endtask

  // fill to DEPTH, hit the full cases with long shifts, then empty it again
  task automatic test_capacity();
    send_idle_pct = 37;
    recv_stall_pct = 37;
    while (mirror_count < DEPTH) send_word(make_word(CMD_PUSH, 0, $urandom));
    send_word(make_word(CMD_PUSH, 0, $urandom));
    send_word(make_word(CMD_INSERT, DEPTH, $urandom));
    send_word(make_word(CMD_INSERT, 0, $urandom));
    send_word(make_word(CMD_INSERT, DEPTH + 1, $urandom));
    send_word(make_word(CMD_INSERT, 127, $urandom));
    send_word(make_word(CMD_READ, DEPTH - 1, '0));
    send_word(make_word(CMD_ERASE, 0, '0));
    send_word(make_word(CMD_INSERT, 0, 32'h8000_0000));
    send_word(make_word(CMD_WRITE, DEPTH - 1, 32'h7fff_ffff));
    send_word(make_word(CMD_BACK, 0, '0));
    send_word(make_word(CMD_ERASE, DEPTH - 1, '0));
    send_word(make_word(CMD_INSERT, DEPTH - 1, 32'h0));
    while (mirror_count > 0) send_word(make_word(CMD_POP, 0, '0));
    send_word(make_word(CMD_POP, 0, '0));
    send_word(make_word(CMD_PUSH, 0, $urandom));
    wait_drain();
  endtask

  // receiver holds off while the sender keeps offering, so the input stalls
  task automatic test_backpressure();
    int n;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_request = 300;
    for (n = 0; n < 16; n++) send_word(random_command(45));
    wait_drain();
  endtask

  task automatic test_random();
    int send_pcts [4];
    int recv_pcts [4];
    int ph;
    int n;
    send_pcts = '{0, 75, 0, 37};
    recv_pcts = '{0, 0, 75, 37};
    for (ph = 0; ph < 4; ph++) begin
      send_idle_pct = send_pcts[ph];
      recv_stall_pct = recv_pcts[ph];
      for (n = 0; n < RANDOM_PER_PHASE; n++)
        send_word(random_command(((n / 50) % 2 == 0) ? 45 : 15));
      wait_drain();
    end
  endtask

  always @(negedge clk) begin
    if (hold_request > 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    out_word_t exp_r;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("result word with nothing pending: %p", out_word);
        fail_count++;
      end else begin
        exp_r = pending_results.pop_front();
        results_checked++;
        status_total[int'(exp_r.status)]++;
        if (out_word.status !== exp_r.status) begin
          $error("status: expected %0d, got %0d", exp_r.status, out_word.status);
          fail_count++;
        end
        if (out_word.read_value !== exp_r.read_value) begin
          $error("read_value: expected %0d, got %0d", exp_r.read_value, out_word.read_value);
          fail_count++;
        end
        if (out_word.element_count !== exp_r.element_count) begin
          $error("element_count: expected %0d, got %0d",
                 exp_r.element_count, out_word.element_count);
          fail_count++;
        end
        if (out_word.is_empty !== exp_r.is_empty) begin
          $error("is_empty: expected %0d, got %0d", exp_r.is_empty, out_word.is_empty);
          fail_count++;
        end
        if (out_word.reported_capacity !== exp_r.reported_capacity) begin
          $error("reported_capacity: expected %0d, got %0d",
                 exp_r.reported_capacity, out_word.reported_capacity);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("timeout: no word moved for %0d cycles", QUIET_LIMIT);
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    foreach (cmd_total[k]) cmd_total[k] = 0;
    foreach (status_total[k]) status_total[k] = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_capacity();
    test_backpressure();
    test_random();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("checked %0d results; push %0d pop %0d insert %0d erase %0d read %0d",
             results_checked, cmd_total[0], cmd_total[1], cmd_total[2], cmd_total[3],
             cmd_total[4]);
    $display("write %0d front %0d back %0d; status ok %0d oob %0d empty %0d full %0d; peak %0d",
             cmd_total[5], cmd_total[6], cmd_total[7], status_total[0], status_total[1],
             status_total[2], status_total[3], peak_count);
    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

>>> indexed_array_insert_erase_top.f
rtl/iaie_pkg.sv
rtl/iaie_ram.sv
rtl/iaie_ctrl.sv
rtl/iaie_dp.sv
rtl/indexed_array_insert_erase_top.sv
tb/sv/indexed_array_insert_erase_top_test.sv
